// ===== hdl/dpm_pkg.sv =====
// Package for the dense Prim spanning tree block: field widths, key limits
// and the input and result word types. No dependencies.
package dpm_pkg;

  localparam int VERTICES_DEF = 16;
  localparam int VTX_W        = 4;
  localparam int WEIGHT_W     = 16;
  localparam int KEY_W        = 17;
  localparam int SUM_W        = 20;

  localparam logic [KEY_W-1:0] KEY_INF = {KEY_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [VTX_W-1:0]    row;
    logic [VTX_W-1:0]    col;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                last;
  } in_word_t;

  typedef struct packed {
    logic [VTX_W-1:0]    vertex;
    logic [VTX_W-1:0]    parent_vertex;
    logic [WEIGHT_W-1:0] edge_cost;
    logic                reached;
    logic [SUM_W-1:0]    total_cost;
    logic                run_end;
  } out_word_t;

endpackage

// ===== hdl/dpm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module dpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dense_prim_mst.sv =====
// Dense Prim minimum spanning tree over an adjacency matrix held in RAM.
// Load: one matrix word per cycle while busy is low; the word marked last
// starts the run. Run: NUM_VERTICES-1 rounds, each a sweep of one matrix row
// through a single relax-and-minimum unit, then one result for each vertex
// from 1 up, in turn (node RAM read, matrix RAM read, saturating add).
// Results are strobed for one cycle and cannot be stalled. Reset (rst_n, sync,
// active low) clears control only; matrix contents persist across runs.
// Depends on dpm_pkg and dpm_ram.
module dense_prim_mst #(
  parameter int NUM_VERTICES = dpm_pkg::VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dpm_pkg::in_word_t  in_data,
  output logic               out_valid,
  output dpm_pkg::out_word_t out_data
);

  import dpm_pkg::*;

  localparam int IDX_W  = $clog2(NUM_VERTICES);
  localparam int ADDR_W = $clog2(NUM_VERTICES * NUM_VERTICES);
  localparam int NODE_W = KEY_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_VERTICES - 1);
  localparam logic [IDX_W-1:0] LAST_RND  = IDX_W'(NUM_VERTICES - 2);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_SWEEP, S_DRAIN, S_PICK, S_OUT_A, S_OUT_B, S_OUT_C
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_VERTICES-1:0] flags_r, flags_nxt;
  logic [NUM_VERTICES-1:0] kvalid_r, kvalid_nxt;
  logic [IDX_W-1:0]        u_r, u_nxt;
  logic [IDX_W-1:0]        round_r, round_nxt;
  logic [IDX_W-1:0]        j_r, j_nxt;
  logic [IDX_W-1:0]        jd_r, jd_nxt;
  logic                    bval_r, bval_nxt;
  logic [ADDR_W-1:0]       base_r, base_nxt;
  logic [KEY_W-1:0]        lowest_r, lowest_nxt;
  logic [IDX_W-1:0]        pick_r, pick_nxt;
  logic                    found_r, found_nxt;
  logic [IDX_W-1:0]        ffree_r, ffree_nxt;
  logic                    ffound_r, ffound_nxt;
  logic [IDX_W-1:0]        v_r, v_nxt;
  logic [IDX_W-1:0]        par_r, par_nxt;
  logic                    reach_r, reach_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r, out_data_nxt;

  // RAM ports
  logic                adj_we;
  logic [ADDR_W-1:0]   adj_waddr;
  logic [ADDR_W-1:0]   adj_raddr;
  logic [WEIGHT_W-1:0] adj_rdata;
  logic                node_we;
  logic [IDX_W-1:0]    node_waddr;
  logic [NODE_W-1:0]   node_wdata;
  logic [IDX_W-1:0]    node_raddr;
  logic [NODE_W-1:0]   node_rdata;

  // Sweep unit signals
  logic               accept;
  logic [IDX_W-1:0]   node_ridx;
  logic [KEY_W-1:0]   key_cur;
  logic [KEY_W-1:0]   wkey;
  logic [KEY_W-1:0]   key_new;
  logic               unvis;
  logic               relax;
  logic [IDX_W-1:0]   node_par;
  logic [KEY_W-1:0]   node_key;
  logic [SUM_W:0]     sum_wide;

  dpm_ram #(.WIDTH(WEIGHT_W), .DEPTH(NUM_VERTICES * NUM_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (in_data.edge_weight),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dpm_ram #(.WIDTH(NODE_W), .DEPTH(NUM_VERTICES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign adj_we    = accept && (32'(in_data.row) < NUM_VERTICES)
                            && (32'(in_data.col) < NUM_VERTICES);
  assign adj_waddr = ADDR_W'(32'(in_data.row) * NUM_VERTICES + 32'(in_data.col));

  // Index that produced the current node RAM read data
  assign node_ridx = (state_r == S_OUT_B) ? v_r : jd_r;

  // Node RAM word is {key, parent}; an entry without its valid bit reads as
  // infinite key, parent 0.
  always_comb begin
    if (kvalid_r[node_ridx]) begin
      node_key = node_rdata[NODE_W-1:IDX_W];
      node_par = node_rdata[IDX_W-1:0];
    end else begin
      node_key = KEY_INF;
      node_par = '0;
    end
  end

  always_comb begin
    key_cur = node_key;
    wkey    = {1'b0, adj_rdata};
    unvis   = !flags_r[jd_r];
    relax   = unvis && (adj_rdata != '0) && (wkey < key_cur);
    key_new = relax ? wkey : key_cur;
  end

  always_comb begin
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    kvalid_nxt    = kvalid_r;
    u_nxt         = u_r;
    round_nxt     = round_r;
    j_nxt         = j_r;
    jd_nxt        = jd_r;
    bval_nxt      = 1'b0;
    base_nxt      = base_r;
    lowest_nxt    = lowest_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    ffree_nxt     = ffree_r;
    ffound_nxt    = ffound_r;
    v_nxt         = v_r;
    par_nxt       = par_r;
    reach_nxt     = reach_r;
    sum_nxt       = sum_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    adj_raddr     = base_r + ADDR_W'(j_r);
    node_raddr    = j_r;
    node_we       = 1'b0;
    node_waddr    = jd_r;
    node_wdata    = {wkey, u_r};
    sum_wide      = {1'b0, sum_r} + (SUM_W + 1)'(adj_rdata);

    // Relax-and-minimum unit, working in the cycle after each row sweep step
    if (bval_r) begin
      if (relax) begin
        node_we            = 1'b1;
        kvalid_nxt[jd_r]   = 1'b1;
      end
      if (unvis) begin
        if (!ffound_r) begin
          ffound_nxt = 1'b1;
          ffree_nxt  = jd_r;
        end
        if (key_new < lowest_r) begin
          lowest_nxt = key_new;
          pick_nxt   = jd_r;
          found_nxt  = 1'b1;
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept && in_data.last) begin
          flags_nxt  = '0;
          kvalid_nxt = '0;
          u_nxt      = '0;
          round_nxt  = '0;
          sum_nxt    = '0;
          state_nxt  = S_ROUND;
        end
      end
      S_ROUND: begin
        flags_nxt[u_r] = 1'b1;
        base_nxt       = ADDR_W'(32'(u_r) * NUM_VERTICES);
        j_nxt          = '0;
        lowest_nxt     = KEY_INF;
        found_nxt      = 1'b0;
        ffound_nxt     = 1'b0;
        state_nxt      = S_SWEEP;
      end
      S_SWEEP: begin
        bval_nxt = 1'b1;
        jd_nxt   = j_r;
        if (j_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        // fall back to the lowest free vertex when no key is finite
        u_nxt = found_r ? pick_r : ffree_r;
        if (round_r == LAST_RND) begin
          v_nxt     = IDX_W'(1);
          state_nxt = S_OUT_A;
        end else begin
          round_nxt = round_r + 1'b1;
          state_nxt = S_ROUND;
        end
      end
      S_OUT_A: begin
        node_raddr = v_r;
        state_nxt  = S_OUT_B;
      end
      S_OUT_B: begin
        node_raddr = v_r;
        par_nxt    = node_par;
        reach_nxt  = (node_key < KEY_INF);
        adj_raddr  = ADDR_W'(32'(v_r) * NUM_VERTICES + 32'(node_par));
        state_nxt  = S_OUT_C;
      end
      S_OUT_C: begin
        sum_nxt = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        out_valid_nxt              = 1'b1;
        out_data_nxt.vertex        = VTX_W'(v_r);
        out_data_nxt.parent_vertex = VTX_W'(par_r);
        out_data_nxt.edge_cost     = adj_rdata;
        out_data_nxt.reached       = reach_r;
        out_data_nxt.total_cost    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        out_data_nxt.run_end       = (v_r == LAST_IDX);
        if (v_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          v_nxt     = v_r + 1'b1;
          state_nxt = S_OUT_A;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bval_r      <= bval_nxt;
      out_valid_r <= out_valid_nxt;
    end
    flags_r    <= flags_nxt;
    kvalid_r   <= kvalid_nxt;
    u_r        <= u_nxt;
    round_r    <= round_nxt;
    j_r        <= j_nxt;
    jd_r       <= jd_nxt;
    base_r     <= base_nxt;
    lowest_r   <= lowest_nxt;
    pick_r     <= pick_nxt;
    found_r    <= found_nxt;
    ffree_r    <= ffree_nxt;
    ffound_r   <= ffound_nxt;
    v_r        <= v_nxt;
    par_r      <= par_nxt;
    reach_r    <= reach_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
